[rtl/pps_pkg.sv]
// Shared types, constants and helpers for the perspective projection setup block.
// No dependencies; every other file in this folder uses it by scoped names.
package pps_pkg;

  // Field widths.
  localparam int FOV_W   = 16;
  localparam int SIZE_W  = 14;
  localparam int DIST_W  = 32;
  localparam int RES_W   = 32;
  localparam int STAT_W  = 2;

  // Stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 136;

  // Pipeline geometry.
  localparam int FY_QBITS   = 24;  // quotient bits of the vertical angle
  localparam int CORDIC_N   = 24;  // rotation steps
  localparam int Q_QBITS    = 32;  // quotient bits of the result divisions
  localparam int LANES      = 4;
  localparam int FYR_W      = 38;  // fov*height*256
  localparam int REM_W      = 64;
  localparam int DEN_W      = 48;
  localparam int CXY_W      = 33;
  localparam int CZ_W       = 26;

  // The vertical angle must stay below half a turn (180 degrees in Q16.16).
  localparam logic [FY_QBITS-1:0] HALF_TURN_LIMIT = 24'd11796480;
  localparam logic [RES_W-1:0]    SAT_POS         = 32'h7FFF_FFFF;
  localparam logic [RES_W-1:0]    SAT_NEG         = 32'h8000_0000;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

  // Lane assignment of the result dividers.
  localparam int LANE_X  = 0;
  localparam int LANE_Y  = 1;
  localparam int LANE_DS = 2;
  localparam int LANE_DO = 3;

  // Arctangent of 2^-i in units of 2^-17 degree.
  localparam logic [23:0] ATAN_Q17 [CORDIC_N] = '{
    24'd5898240, 24'd3481934, 24'd1839759, 24'd933890, 24'd468757, 24'd234607,
    24'd117332,  24'd58670,   24'd29335,   24'd14668,  24'd7334,   24'd3667,
    24'd1833,    24'd917,     24'd458,     24'd229,    24'd115,    24'd57,
    24'd29,      24'd14,      24'd7,       24'd4,      24'd2,      24'd1
  };

  // Everything that travels down the chain with one request.
  typedef struct packed {
    logic                           bad;
    logic [SIZE_W-1:0]              w;
    logic [SIZE_W-1:0]              h;
    logic [DIST_W-1:0]              nr;
    logic [DIST_W-1:0]              fr;
    logic [FYR_W-1:0]               fyr;
    logic [FY_QBITS-1:0]            fy;
    logic signed [CXY_W-1:0]        cx;
    logic signed [CXY_W-1:0]        cy;
    logic signed [CZ_W-1:0]         cz;
    logic                           ysz;
    logic [LANES-1:0]               ovf;
    logic [LANES-1:0][REM_W-1:0]    rem;
    logic [LANES-1:0][DEN_W-1:0]    den;
    logic [LANES-1:0][Q_QBITS-1:0]  quo;
  } item_t;

  // Signed saturation of a quotient magnitude; bit 32 flags saturation.
  function automatic logic [RES_W:0] clamp_res(input logic neg, input logic ovf,
                                               input logic [Q_QBITS-1:0] mag);
    logic [RES_W:0] r;
    if (neg) begin
      if (ovf || (mag > SAT_NEG)) r = {1'b1, SAT_NEG};
      else                        r = {1'b0, RES_W'(32'd0 - mag)};
    end else begin
      if (ovf || (mag > SAT_POS)) r = {1'b1, SAT_POS};
      else                        r = {1'b0, mag};
    end
    return r;
  endfunction

endpackage

[rtl/perspective_projection_setup.sv]
// Top level of the perspective projection setup: entry register, cell chain, output register.
// Depends on pps_pkg, pps_fydiv_cell, pps_cordic_cell, pps_prod_cell and pps_quot_cell.
//
// The block takes one request per clock while the chain advances and returns one result per
// request, in order. The request passes through one entry register, 25 division cells for
// the vertical angle, 24 CORDIC cells, one multiplier cell, 33 division cells that work the
// four result quotients side by side, and the output register, one register per advance.
// The whole chain advances together whenever the output register is empty or being taken,
// so a result that waits at the output holds the chain while the stages behind it stay
// filled.
module perspective_projection_setup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request: fov_x_deg, target_width, target_height, near_dist, far_dist, from bit 0.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Result: x_scale, y_scale, depth_scale, depth_offset, status, from bit 0.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pps_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int FY_END  = pps_pkg::FY_QBITS + 1;
  localparam int COR_END = FY_END + pps_pkg::CORDIC_N;
  localparam int PRD_END = COR_END + 1;
  localparam int Q_END   = PRD_END + pps_pkg::Q_QBITS + 1;

  logic           en;
  pps_pkg::item_t c_it  [Q_END+1];
  logic           c_vld [Q_END+1];
  pps_pkg::item_t entry_d, cor_in;
  logic [pps_pkg::FOV_W-1:0] fov;
  logic           out_vld_q;
  logic [pps_pkg::OUT_DATA_W-1:0] out_q, out_d;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Entry: unpack and start the angle division.
  always_comb begin
    entry_d    = '0;
    fov        = s_axis_tdata[15:0];
    entry_d.w  = s_axis_tdata[29:16];
    entry_d.h  = s_axis_tdata[43:30];
    entry_d.nr = s_axis_tdata[75:44];
    entry_d.fr = s_axis_tdata[107:76];
    entry_d.fyr = {30'(fov) * 30'(entry_d.h), 8'h00};
    entry_d.bad = (entry_d.w == '0) || (entry_d.h == '0) || (entry_d.nr == entry_d.fr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld[0] <= 1'b0;
    end else if (en) begin
      c_vld[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_it[0] <= entry_d;
    end
  end

  // Vertical angle division cells.
  for (genvar k = 0; k < FY_END; k++) begin : g_fy
    pps_fydiv_cell #(.I(pps_pkg::FY_QBITS - k)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(c_vld[k]),   .item_i(c_it[k]),
      .valid_o(c_vld[k+1]), .item_o(c_it[k+1])
    );
  end

  // Angle range check and CORDIC start vector.
  always_comb begin
    cor_in     = c_it[FY_END];
    cor_in.bad = c_it[FY_END].bad || (c_it[FY_END].fy == '0) ||
                 (c_it[FY_END].fy >= pps_pkg::HALF_TURN_LIMIT);
    cor_in.cx  = 33'sh0_4000_0000;
    cor_in.cy  = '0;
    cor_in.cz  = $signed({2'b00, c_it[FY_END].fy});
  end

  for (genvar k = 0; k < pps_pkg::CORDIC_N; k++) begin : g_cor
    if (k == 0) begin : g_first
      pps_cordic_cell #(.I(k)) u_cell (
        .clk_i, .rst_ni, .en_i(en),
        .valid_i(c_vld[FY_END]),     .item_i(cor_in),
        .valid_o(c_vld[FY_END+k+1]), .item_o(c_it[FY_END+k+1])
      );
    end else begin : g_rest
      pps_cordic_cell #(.I(k)) u_cell (
        .clk_i, .rst_ni, .en_i(en),
        .valid_i(c_vld[FY_END+k]),   .item_i(c_it[FY_END+k]),
        .valid_o(c_vld[FY_END+k+1]), .item_o(c_it[FY_END+k+1])
      );
    end
  end

  pps_prod_cell u_prod (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(c_vld[COR_END]), .item_i(c_it[COR_END]),
    .valid_o(c_vld[PRD_END]), .item_o(c_it[PRD_END])
  );

  // Result division cells.
  for (genvar k = 0; k < pps_pkg::Q_QBITS + 1; k++) begin : g_q
    pps_quot_cell #(.I(pps_pkg::Q_QBITS - k)) u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(c_vld[PRD_END+k]),   .item_i(c_it[PRD_END+k]),
      .valid_o(c_vld[PRD_END+k+1]), .item_o(c_it[PRD_END+k+1])
    );
  end

  // Saturation, signs and status.
  always_comb begin
    logic [pps_pkg::RES_W:0] rx, ry, rs, ro;
    logic neg, sat;
    neg = c_it[Q_END].fr < c_it[Q_END].nr;
    rx  = pps_pkg::clamp_res(1'b0, c_it[Q_END].ovf[pps_pkg::LANE_X],
                             c_it[Q_END].quo[pps_pkg::LANE_X]);
    ry  = pps_pkg::clamp_res(1'b0, c_it[Q_END].ovf[pps_pkg::LANE_Y],
                             c_it[Q_END].quo[pps_pkg::LANE_Y]);
    rs  = pps_pkg::clamp_res(neg, c_it[Q_END].ovf[pps_pkg::LANE_DS],
                             c_it[Q_END].quo[pps_pkg::LANE_DS]);
    ro  = pps_pkg::clamp_res(!neg, c_it[Q_END].ovf[pps_pkg::LANE_DO],
                             c_it[Q_END].quo[pps_pkg::LANE_DO]);
    if (c_it[Q_END].ysz) begin
      rx = {1'b1, pps_pkg::SAT_POS};
      ry = {1'b1, pps_pkg::SAT_POS};
    end
    sat = rx[32] | ry[32] | rs[32] | ro[32];
    if (c_it[Q_END].bad) begin
      out_d = {6'h00, pps_pkg::ST_INVALID, 128'h0};
    end else begin
      out_d = {6'h00, (sat ? pps_pkg::ST_SAT : pps_pkg::ST_OK),
               ro[31:0], rs[31:0], ry[31:0], rx[31:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= c_vld[Q_END];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // A finished item in the last cell reaches the output on the next advance.
  a_last_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && c_vld[Q_END]) |=> m_axis_tvalid)
    else $error("finished item did not reach the output register");

  // A held result stalls the whole chain, entry included.
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("request taken while the chain is stalled");

  // The status field never carries the unused code.
  a_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[129:128] != 2'd3))
    else $error("undefined status code");

  // Invalid requests give all-zero result fields.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[129:128] == pps_pkg::ST_INVALID))
      |-> (m_axis_tdata[127:0] == '0))
    else $error("invalid request with non-zero results");

endmodule

[rtl/pps_fydiv_cell.sv]
// One restoring-division cell for the vertical angle, fov*height*256/width.
// Depends on pps_pkg; the top bit position only detects an oversized quotient.
module pps_fydiv_cell #(
  parameter int I = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pps_pkg::item_t item_i,
  output logic           valid_o,
  output pps_pkg::item_t item_o
);

  localparam int QI = (I < pps_pkg::FY_QBITS) ? I : 0;

  pps_pkg::item_t item_d, item_q;
  logic           valid_q;
  logic [pps_pkg::FYR_W-1:0] shifted;
  logic           ge;

  // Compare the partial remainder with the shifted divisor.
  always_comb begin
    item_d  = item_i;
    shifted = pps_pkg::FYR_W'(item_i.w) << I;
    ge      = item_i.fyr >= shifted;
    if (I == pps_pkg::FY_QBITS) begin
      item_d.bad = item_i.bad | ge;
    end else if (ge) begin
      item_d.fyr    = item_i.fyr - shifted;
      item_d.fy[QI] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/pps_cordic_cell.sv]
// One CORDIC rotation step toward the half angle, giving scaled cosine and sine.
// Depends on pps_pkg for the arctangent table and the request record.
module pps_cordic_cell #(
  parameter int I = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pps_pkg::item_t item_i,
  output logic           valid_o,
  output pps_pkg::item_t item_o
);

  pps_pkg::item_t item_d, item_q;
  logic           valid_q;
  logic signed [pps_pkg::CXY_W-1:0] dx, dy;
  logic signed [pps_pkg::CZ_W-1:0]  ang;

  // Arithmetic shifts round toward minus infinity.
  always_comb begin
    item_d = item_i;
    dx     = item_i.cy >>> I;
    dy     = item_i.cx >>> I;
    ang    = $signed({2'b00, pps_pkg::ATAN_Q17[I]});
    if (!item_i.cz[pps_pkg::CZ_W-1]) begin
      item_d.cx = item_i.cx - dx;
      item_d.cy = item_i.cy + dy;
      item_d.cz = item_i.cz - ang;
    end else begin
      item_d.cx = item_i.cx + dx;
      item_d.cy = item_i.cy - dy;
      item_d.cz = item_i.cz + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/pps_prod_cell.sv]
// Forms the numerators and denominators of the four result divisions.
// Depends on pps_pkg; holds three of the chain's multipliers.
module pps_prod_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pps_pkg::item_t item_i,
  output logic           valid_o,
  output pps_pkg::item_t item_o
);

  pps_pkg::item_t item_d, item_q;
  logic           valid_q;
  logic [30:0]    cosv, sinv;
  logic [44:0]    xh, sw;
  logic [63:0]    nf;
  logic           neg;
  logic [31:0]    diff;

  always_comb begin
    item_d = item_i;
    // A negative cosine counts as zero; a non-positive sine forces saturation.
    cosv       = item_i.cx[pps_pkg::CXY_W-1] ? 31'd0 : item_i.cx[30:0];
    item_d.ysz = item_i.cy[pps_pkg::CXY_W-1] || (item_i.cy == '0);
    sinv       = item_i.cy[30:0];
    xh         = 45'(cosv) * 45'(item_i.h);
    sw         = 45'(sinv) * 45'(item_i.w);
    nf         = 64'(item_i.nr) * 64'(item_i.fr);
    neg        = item_i.fr < item_i.nr;
    diff       = neg ? (item_i.nr - item_i.fr) : (item_i.fr - item_i.nr);

    item_d.rem[pps_pkg::LANE_X]  = {3'b000, xh, 16'h0000};
    item_d.den[pps_pkg::LANE_X]  = {3'b000, sw};
    item_d.rem[pps_pkg::LANE_Y]  = {17'h0, cosv, 16'h0000};
    item_d.den[pps_pkg::LANE_Y]  = {17'h0, sinv};
    item_d.rem[pps_pkg::LANE_DS] = {16'h0000, item_i.fr, 16'h0000};
    item_d.den[pps_pkg::LANE_DS] = {16'h0000, diff};
    item_d.rem[pps_pkg::LANE_DO] = nf;
    item_d.den[pps_pkg::LANE_DO] = {16'h0000, diff};
    item_d.ovf = '0;
    item_d.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/pps_quot_cell.sv]
// One restoring-division cell, one quotient bit for each of the four result lanes.
// Depends on pps_pkg; the top bit position only detects a quotient of 2^32 or more.
module pps_quot_cell #(
  parameter int I = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pps_pkg::item_t item_i,
  output logic           valid_o,
  output pps_pkg::item_t item_o
);

  localparam int QI  = (I < pps_pkg::Q_QBITS) ? I : 0;
  localparam int CMP_W = pps_pkg::DEN_W + pps_pkg::Q_QBITS;

  pps_pkg::item_t item_d, item_q;
  logic           valid_q;
  logic [pps_pkg::LANES-1:0][CMP_W-1:0] shifted;
  logic [pps_pkg::LANES-1:0]            ge;

  // The lanes are independent; each compares and subtracts once.
  always_comb begin
    item_d = item_i;
    for (int l = 0; l < pps_pkg::LANES; l++) begin
      shifted[l] = CMP_W'(item_i.den[l]) << I;
      ge[l]      = CMP_W'(item_i.rem[l]) >= shifted[l];
      if (I == pps_pkg::Q_QBITS) begin
        item_d.ovf[l] = item_i.ovf[l] | ge[l];
      end else if (ge[l]) begin
        item_d.rem[l]     = item_i.rem[l] - shifted[l][pps_pkg::REM_W-1:0];
        item_d.quo[l][QI] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[bench/perspective_projection_setup_test.sv]
// Self-checking bench for the perspective projection setup block.
// Depends on pps_pkg and perspective_projection_setup; it predicts every result and
// compares it with what the block returns, in order.
module perspective_projection_setup_test;

  typedef struct packed {
    logic [pps_pkg::DIST_W-1:0] far_d;
    logic [pps_pkg::DIST_W-1:0] near_d;
    logic [pps_pkg::SIZE_W-1:0] height;
    logic [pps_pkg::SIZE_W-1:0] width;
    logic [pps_pkg::FOV_W-1:0]  fov;
  } lens_t;

  typedef struct packed {
    logic [pps_pkg::STAT_W-1:0] status;
    logic [pps_pkg::RES_W-1:0]  depth_offset;
    logic [pps_pkg::RES_W-1:0]  depth_scale;
    logic [pps_pkg::RES_W-1:0]  y_scale;
    logic [pps_pkg::RES_W-1:0]  x_scale;
  } proj_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  // Request: fov_x_deg, target_width, target_height, near_dist, far_dist, from bit 0.
  logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // Result: x_scale, y_scale, depth_scale, depth_offset, status, from bit 0.
  logic [pps_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  lens_t  pending_lens[$];
  proj_t  expected_proj[$];
  logic   failed;
  logic   stimulus_done;
  int     cycle_count;
  int     sent_count;
  int     send_gap;
  int     take_gap;
  logic   hold_done;
  lens_t  lens_now;

  perspective_projection_setup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Saturate a magnitude to a signed word; bit 32 flags saturation.
  function automatic logic [pps_pkg::RES_W:0] saturate(input logic neg,
                                                       input longint unsigned mag);
    if (neg) begin
      if (mag > 64'h8000_0000) return {1'b1, pps_pkg::SAT_NEG};
      return {1'b0, (32'd0 - mag[31:0])};
    end
    if (mag > 64'h7FFF_FFFF) return {1'b1, pps_pkg::SAT_POS};
    return {1'b0, mag[31:0]};
  endfunction

  // Projection terms for one lens request.
  function automatic proj_t project_lens(input lens_t ln);
    proj_t                   pr;
    longint unsigned         fy, c16, s, diff, wv, hv, nv, fv;
    longint                  cx, cy, cz, dx, dy;
    logic [pps_pkg::RES_W:0] r;
    logic                    sat, neg;
    pr  = '0;
    sat = 1'b0;
    wv  = ln.width;
    hv  = ln.height;
    nv  = ln.near_d;
    fv  = ln.far_d;
    fy  = (wv != 0) ? ((longint'(ln.fov) * hv) << 8) / wv : 0;
    if (wv == 0 || hv == 0 || nv == fv || fy == 0 || fy >= pps_pkg::HALF_TURN_LIMIT) begin
      pr.status = pps_pkg::ST_INVALID;
      return pr;
    end
    cx = longint'(1) << 30;
    cy = 0;
    cz = longint'(fy);
    for (int i = 0; i < pps_pkg::CORDIC_N; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= longint'(pps_pkg::ATAN_Q17[i]);
      end else begin
        cx += dx; cy -= dy; cz += longint'(pps_pkg::ATAN_Q17[i]);
      end
    end
    if (cx < 0) cx = 0;
    if (cy <= 0) begin
      pr.x_scale = pps_pkg::SAT_POS;
      pr.y_scale = pps_pkg::SAT_POS;
      sat = 1'b1;
    end else begin
      c16 = longint'(cx) << 16;
      s   = cy;
      r = saturate(1'b0, (c16 * hv) / (s * wv));
      pr.x_scale = r[31:0]; sat |= r[32];
      r = saturate(1'b0, c16 / s);
      pr.y_scale = r[31:0]; sat |= r[32];
    end
    neg  = fv < nv;
    diff = neg ? nv - fv : fv - nv;
    r = saturate(neg, (fv << 16) / diff);
    pr.depth_scale = r[31:0]; sat |= r[32];
    r = saturate(!neg, (nv * fv) / diff);
    pr.depth_offset = r[31:0]; sat |= r[32];
    pr.status = sat ? pps_pkg::ST_SAT : pps_pkg::ST_OK;
    return pr;
  endfunction

  // Mostly short gaps, now and then a long one, and stretches with none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic lens_t make_lens(input int fov, input int w, input int h,
                                      input longint unsigned n, input longint unsigned f);
    lens_t ln;
    ln.fov = fov[15:0]; ln.width = w[13:0]; ln.height = h[13:0];
    ln.near_d = n[31:0]; ln.far_d = f[31:0];
    return ln;
  endfunction

  // Stimulus: directed corner cases, then random requests.
  initial begin
    lens_t ln;
    int    k;
    stimulus_done = 1'b0;
    pending_lens.push_back(make_lens(90 << 8, 0, 480, 32'h0001_0000, 32'h0064_0000));
    pending_lens.push_back(make_lens(90 << 8, 640, 0, 32'h0001_0000, 32'h0064_0000));
    pending_lens.push_back(make_lens(90 << 8, 640, 480, 32'h0005_0000, 32'h0005_0000));
    pending_lens.push_back(make_lens(0, 640, 480, 32'h0001_0000, 32'h0064_0000));
    pending_lens.push_back(make_lens(16'hFFFF, 640, 480, 32'h0001_0000, 32'h0064_0000));
    pending_lens.push_back(make_lens(180 << 8, 100, 100, 32'h0001_0000, 32'h0064_0000));
    pending_lens.push_back(make_lens((180 << 8) - 1, 100, 100, 32'h0001_0000, 32'h0002_0000));
    pending_lens.push_back(make_lens(1, 16383, 16383, 0, 32'hFFFF_FFFF));
    pending_lens.push_back(make_lens(1, 256, 1, 32'h0001_0000, 32'h0002_0000));
    pending_lens.push_back(make_lens(1, 16383, 1, 32'h0001_0000, 32'h0002_0000));
    pending_lens.push_back(make_lens(90 << 8, 640, 480, 32'h0001_0000, 32'h0064_0000));
    pending_lens.push_back(make_lens(60 << 8, 1920, 1080, 32'h0064_0000, 32'h0001_0000));
    pending_lens.push_back(make_lens(60 << 8, 1, 16383, 32'h0001_0000, 32'h0002_0000));
    pending_lens.push_back(make_lens(90 << 8, 16383, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFE));
    pending_lens.push_back(make_lens(90 << 8, 16383, 16383, 32'hFFFF_FFFE, 32'hFFFF_FFFF));
    pending_lens.push_back(make_lens(45 << 8, 800, 600, 0, 1));
    pending_lens.push_back(make_lens(45 << 8, 800, 600, 1, 0));
    pending_lens.push_back(make_lens(120 << 8, 1000, 1000, 32'h0000_0100, 32'hFFFF_FFFF));
    for (k = 0; k < 400; k++) begin
      ln = make_lens(0, 0, 0, 0, 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          ln = lens_t'({$urandom, $urandom, $urandom, $urandom});
        end
        2: begin
          ln = make_lens($urandom_range(1, 16'hFFFF), $urandom_range(0, 3),
                         $urandom_range(0, 3), $urandom_range(0, 2), $urandom_range(0, 2));
        end
        default: begin
          ln = make_lens($urandom_range(10 << 8, 150 << 8), $urandom_range(1, 16383),
                         $urandom_range(1, 16383), $urandom, $urandom);
          if ($urandom_range(0, 3) == 0) begin
            ln.height = 14'($urandom_range(1, 16383));
            ln.width  = 14'(ln.height + $urandom_range(0, 16383 - ln.height));
          end
        end
      endcase
      pending_lens.push_back(ln);
    end
    stimulus_done = 1'b1;
  end

  // Reset and the end of the run.
  initial begin
    failed        = 1'b0;
    rst_ni        = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stimulus_done && pending_lens.size() == 0 && !s_axis_tvalid &&
             expected_proj.size() == 0)) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    if (!failed && expected_proj.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Request driver: predicts each accepted request and offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    logic busy;
    busy = 1'b0;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      sent_count    <= 0;
      send_gap      <= 0;
      hold_done     <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_proj.push_back(project_lens(lens_t'(s_axis_tdata[107:0])));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (sent_count == 200 && !hold_done) begin
          // Let the pipeline drain completely once.
          s_axis_tvalid <= 1'b0;
          if (expected_proj.size() == 0 && !s_axis_tvalid) hold_done <= 1'b1;
        end else if (pending_lens.size() > 0) begin
          lens_now = pending_lens.pop_front();
          s_axis_tdata  <= {4'h0, lens_now};
          s_axis_tvalid <= 1'b1;
          sent_count    <= sent_count + 1;
          send_gap      <= ((sent_count / 60) % 3 == 1) ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    proj_t want, got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      take_gap      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = proj_t'(m_axis_tdata[129:0]);
        if (expected_proj.size() == 0) begin
          $display("%0t: result with none expected, got %h", $time, got);
          failed <= 1'b1;
        end else begin
          want = expected_proj.pop_front();
          if (got.x_scale !== want.x_scale) begin
            $display("%0t: x_scale expected %h got %h", $time, want.x_scale, got.x_scale);
            failed <= 1'b1;
          end
          if (got.y_scale !== want.y_scale) begin
            $display("%0t: y_scale expected %h got %h", $time, want.y_scale, got.y_scale);
            failed <= 1'b1;
          end
          if (got.depth_scale !== want.depth_scale) begin
            $display("%0t: depth_scale expected %h got %h", $time,
                     want.depth_scale, got.depth_scale);
            failed <= 1'b1;
          end
          if (got.depth_offset !== want.depth_offset) begin
            $display("%0t: depth_offset expected %h got %h", $time,
                     want.depth_offset, got.depth_offset);
            failed <= 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            failed <= 1'b1;
          end
        end
      end
      if (take_gap > 0) begin
        take_gap      <= take_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (m_axis_tready && (cycle_count / 700) % 3 != 2) take_gap <= pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
